@@ rtl/dwio_pkg.sv @@
// dwio_pkg: shared types, constants and tables for the dead-wheel imu odometry core
// no dependencies; imported by the interfaces' users, the controller and the datapath
package dwio_pkg;

    // fixed-point constants
    localparam int ATAN_LEN = 24;
    localparam logic signed [17:0] PI_Q13 = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [37:0] CORDIC_K_Q30 = 38'sd652032874;
    localparam logic [15:0] RADIUS_RESET = 16'd1638;
    localparam int TICK_UOPS = 16;
    localparam int IMU_UOPS = 9;

    typedef enum logic [1:0] {
        ACT_ENC  = 2'd0,
        ACT_IMU  = 2'd1,
        ACT_POSE = 2'd2,
        ACT_TICK = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_INV_X   = 2'd1,
        REG_INV_Y   = 2'd2,
        REG_USE_IMU = 2'd3
    } cfg_reg_t;

    // multiplier operand pairs
    typedef enum logic [4:0] {
        M_NONE, M_HSHC, M_HCHC, M_HSHS, M_DX, M_DY, M_VX, M_VY,
        M_PXCY, M_PYSY, M_PXSY, M_PYCY, M_VXCY, M_VYSY, M_VXSY, M_VYCY,
        M_QXX, M_QYY, M_QZZ, M_QWW, M_QXY, M_QWZ, M_QXZ, M_QWY
    } mul_sel_t;

    // what is done with the registered product
    typedef enum logic [4:0] {
        P_NONE, P_SY, P_ACC, P_CY, P_PX, P_PY, P_VX, P_VY, P_WX, P_WY,
        P_VWX, P_VWY, P_QXX, P_QYY, P_QZZ, P_QWW, P_QXY, P_QWZ, P_QXZ, P_QWY
    } post_sel_t;

    typedef enum logic [2:0] {
        CO_NONE, CO_INIT_ROT, CO_INIT_VEC, CO_STEP_ROT, CO_STEP_VEC
    } cordic_op_t;

    typedef struct packed {
        mul_sel_t  mul;
        post_sel_t post;
    } uop_t;

    typedef struct packed {
        logic       capture;
        logic       commit_enc;
        logic       commit_pose;
        logic       commit_imu;
        logic       emit;
        cordic_op_t cordic_op;
        logic [4:0] step;
        mul_sel_t   mul_sel;
        post_sel_t  post_sel;
    } dp_cmd_t;

    typedef struct packed {
        action_t action;
        logic    use_imu;
        logic    tick_ok;
        logic    out_free;
    } dp_stat_t;

    typedef struct packed {
        action_t            action;
        logic signed [31:0] pos_x_in;
        logic signed [31:0] pos_y_in;
        logic signed [31:0] speed_x_in;
        logic signed [31:0] speed_y_in;
        logic signed [15:0] quat_x_in;
        logic signed [15:0] quat_y_in;
        logic signed [15:0] quat_z_in;
        logic signed [15:0] quat_w_in;
        logic signed [15:0] rate_or_yaw;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] heading;
        logic signed [15:0] heading_quat_z;
        logic signed [15:0] heading_quat_w;
        logic signed [31:0] vel_x_world;
        logic signed [31:0] vel_y_world;
        logic signed [15:0] yaw_rate_out;
    } res_t;

    // arctangent of 2^-i in Q2.30
    function automatic logic [31:0] atan_tab(input logic [4:0] i);
        case (i)
            5'd0:  return 32'd843314856;
            5'd1:  return 32'd497837829;
            5'd2:  return 32'd263043836;
            5'd3:  return 32'd133525158;
            5'd4:  return 32'd67021686;
            5'd5:  return 32'd33543515;
            5'd6:  return 32'd16775850;
            5'd7:  return 32'd8388437;
            5'd8:  return 32'd4194282;
            5'd9:  return 32'd2097149;
            5'd10: return 32'd1048575;
            5'd11: return 32'd524287;
            5'd12: return 32'd262143;
            5'd13: return 32'd131071;
            5'd14: return 32'd65535;
            5'd15: return 32'd32767;
            5'd16: return 32'd16383;
            5'd17: return 32'd8191;
            5'd18: return 32'd4095;
            5'd19: return 32'd2047;
            5'd20: return 32'd1023;
            5'd21: return 32'd511;
            5'd22: return 32'd255;
            5'd23: return 32'd127;
            default: return 32'd0;
        endcase
    endfunction

    // wrap into (-pi, pi]; operands stay within one turn of the range
    function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a > PI_Q13)
            r = a - TWO_PI_Q13;
        else if (a <= -PI_Q13)
            r = a + TWO_PI_Q13;
        return r[15:0];
    endfunction

    // clamp to plus or minus one in Q2.30
    function automatic logic signed [31:0] clamp_q30(input logic signed [68:0] v);
        if (v > 69'sd1073741824)
            return 32'sd1073741824;
        else if (v < -69'sd1073741824)
            return -32'sd1073741824;
        else
            return v[31:0];
    endfunction

    // saturate to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [68:0] v);
        if (v > 69'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -69'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // tick sequence: multiply, then use the registered product in the next cycle
    function automatic uop_t tick_uop(input logic [4:0] k);
        case (k)
            5'd0:  return '{M_HSHC, P_NONE};
            5'd1:  return '{M_HCHC, P_SY};
            5'd2:  return '{M_HSHS, P_ACC};
            5'd3:  return '{M_DX,   P_CY};
            5'd4:  return '{M_DY,   P_PX};
            5'd5:  return '{M_VX,   P_PY};
            5'd6:  return '{M_VY,   P_VX};
            5'd7:  return '{M_PXCY, P_VY};
            5'd8:  return '{M_PYSY, P_ACC};
            5'd9:  return '{M_PXSY, P_WX};
            5'd10: return '{M_PYCY, P_ACC};
            5'd11: return '{M_VXCY, P_WY};
            5'd12: return '{M_VYSY, P_ACC};
            5'd13: return '{M_VXSY, P_VWX};
            5'd14: return '{M_VYCY, P_ACC};
            5'd15: return '{M_NONE, P_VWY};
            default: return '{M_NONE, P_NONE};
        endcase
    endfunction

    // imu sequence: quaternion products for norm, yaw terms and gimbal test
    function automatic uop_t imu_uop(input logic [4:0] k);
        case (k)
            5'd0: return '{M_QXX,  P_NONE};
            5'd1: return '{M_QYY,  P_QXX};
            5'd2: return '{M_QZZ,  P_QYY};
            5'd3: return '{M_QWW,  P_QZZ};
            5'd4: return '{M_QXY,  P_QWW};
            5'd5: return '{M_QWZ,  P_QXY};
            5'd6: return '{M_QXZ,  P_QWZ};
            5'd7: return '{M_QWY,  P_QXZ};
            5'd8: return '{M_NONE, P_QWY};
            default: return '{M_NONE, P_NONE};
        endcase
    endfunction

endpackage

@@ rtl/dwio_if.sv @@
// dwio_if: request channels of the odometry core, one for samples and one for results
// no dependencies
interface dwio_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] speed_x_in;
    logic signed [31:0] speed_y_in;
    logic signed [15:0] quat_x_in;
    logic signed [15:0] quat_y_in;
    logic signed [15:0] quat_z_in;
    logic signed [15:0] quat_w_in;
    logic signed [15:0] rate_or_yaw;

    modport source (output valid, action, pos_x_in, pos_y_in, speed_x_in, speed_y_in,
                    quat_x_in, quat_y_in, quat_z_in, quat_w_in, rate_or_yaw,
                    input ready);
    modport sink (input valid, action, pos_x_in, pos_y_in, speed_x_in, speed_y_in,
                  quat_x_in, quat_y_in, quat_z_in, quat_w_in, rate_or_yaw,
                  output ready);
endinterface

interface dwio_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] heading;
    logic signed [15:0] heading_quat_z;
    logic signed [15:0] heading_quat_w;
    logic signed [31:0] vel_x_world;
    logic signed [31:0] vel_y_world;
    logic signed [15:0] yaw_rate_out;

    modport source (output valid, pose_x, pose_y, heading, heading_quat_z, heading_quat_w,
                    vel_x_world, vel_y_world, yaw_rate_out,
                    input ready);
    modport sink (input valid, pose_x, pose_y, heading, heading_quat_z, heading_quat_w,
                  vel_x_world, vel_y_world, yaw_rate_out,
                  output ready);
endinterface

@@ rtl/dead_wheel_imu_odometry_core.sv @@
// tick: cordic rotation of the heading, then the multiply sequence on the one shared
// multiplier, then the result is loaded; imu sample: multiply sequence, then vectoring
// cordic; encoder sample and set pose commit at decode. A request is taken only in idle,
// after the previous one is through; a result waiting in the output register holds only a tick's result load.
// Reset (rst_n, asynchronous, active low) loads register defaults, clears the odometry
// state and marks both the encoder and the imu sample fresh.
module dead_wheel_imu_odometry_core
    import dwio_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    dwio_in_if.sink     sample,
    dwio_out_if.source  result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    item_t    item;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    res_t     res;
    logic     in_ready;
    logic     out_valid;

    // request payload into one struct
    always_comb
    begin
        item.action      = action_t'(sample.action);
        item.pos_x_in    = sample.pos_x_in;
        item.pos_y_in    = sample.pos_y_in;
        item.speed_x_in  = sample.speed_x_in;
        item.speed_y_in  = sample.speed_y_in;
        item.quat_x_in   = sample.quat_x_in;
        item.quat_y_in   = sample.quat_y_in;
        item.quat_z_in   = sample.quat_z_in;
        item.quat_w_in   = sample.quat_w_in;
        item.rate_or_yaw = sample.rate_or_yaw;
    end

    // result channel
    always_comb
    begin
        sample.ready          = in_ready;
        result.valid          = out_valid;
        result.pose_x         = res.pose_x;
        result.pose_y         = res.pose_y;
        result.heading        = res.heading;
        result.heading_quat_z = res.heading_quat_z;
        result.heading_quat_w = res.heading_quat_w;
        result.vel_x_world    = res.vel_x_world;
        result.vel_y_world    = res.vel_y_world;
        result.yaw_rate_out   = res.yaw_rate_out;
    end

    dwio_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dwio_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .res       (res),
        .stat      (stat)
    );

endmodule

@@ rtl/dwio_dp.sv @@
// dwio_dp: datapath with state, config registers, shared multiplier and cordic unit
// depends on dwio_pkg; driven by dwio_ctrl commands
module dwio_dp
    import dwio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  item_t       item,
    input  dp_cmd_t     cmd,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        out_ready,
    output logic        out_valid,
    output res_t        res,
    output dp_stat_t    stat
);

    localparam logic signed [68:0] RND16 = 69'sd32768;
    localparam logic signed [68:0] RND29 = 69'sd268435456;
    localparam logic signed [68:0] RND30 = 69'sd536870912;

    // config and architectural state
    logic [15:0]        radius_reg;
    logic               inv_x_reg, inv_y_reg, use_imu_reg;
    logic signed [31:0] angle_x_reg, angle_y_reg, prior_x_reg, prior_y_reg;
    logic signed [31:0] speed_x_reg, speed_y_reg, pose_x_reg, pose_y_reg;
    logic signed [15:0] imu_heading_reg, imu_rate_reg, heading_offset_reg;
    logic               enc_fresh_reg, imu_fresh_reg, out_valid_reg;

    // scratch
    item_t              item_reg;
    logic signed [67:0] prod_reg, acc_reg;
    logic signed [31:0] sy_reg, cy_reg, vwx_reg, vwy_reg;
    logic signed [33:0] px_reg, py_reg, vx_reg, vy_reg;
    logic signed [35:0] n_reg, xa_reg, ya_reg, g_reg;
    logic signed [37:0] x_reg, y_reg;
    logic signed [33:0] z_reg;
    logic               deg_reg;
    res_t               res_reg;

    // combinational
    logic signed [15:0] yaw_c;
    logic signed [31:0] hs_c, hc_c;
    logic signed [32:0] dx33, dy33;
    logic signed [33:0] dx_c, dy_c, sx_c, sy_c;
    logic signed [32:0] rad33;
    logic signed [34:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [68:0] prod_w, sub_sum, add_sum, r16, r29, sub30, add30;
    logic signed [37:0] sh_x, sh_y;
    logic signed [33:0] atan_c;
    logic signed [37:0] ya2, xa38, vx_init, vy_init;
    logic signed [33:0] vz_init;
    logic signed [36:0] g2, gabs;
    logic               vec_deg;
    logic signed [34:0] z_rnd;
    logic signed [15:0] yaw_imu;
    logic signed [32:0] qz_rnd, qw_rnd;

    // heading and cordic sin/cos of half heading
    always_comb
    begin
        yaw_c = wrap_q13(18'(imu_heading_reg) + 18'(heading_offset_reg));
        hs_c  = clamp_q30(69'(y_reg));
        hc_c  = clamp_q30(69'(x_reg));
        qz_rnd = (33'(hs_c) + 33'sd32768) >>> 16;
        qw_rnd = (33'(hc_c) + 33'sd32768) >>> 16;
    end

    // wheel deltas and speeds with direction applied
    always_comb
    begin
        dx33  = 33'(angle_x_reg) - 33'(prior_x_reg);
        dy33  = 33'(angle_y_reg) - 33'(prior_y_reg);
        dx_c  = inv_x_reg ? -34'(dx33) : 34'(dx33);
        dy_c  = inv_y_reg ? -34'(dy33) : 34'(dy33);
        sx_c  = inv_x_reg ? -34'(speed_x_reg) : 34'(speed_x_reg);
        sy_c  = inv_y_reg ? -34'(speed_y_reg) : 34'(speed_y_reg);
        rad33 = 33'($signed({1'b0, radius_reg}));
    end

    // shared multiplier operand select
    always_comb
    begin
        case (cmd.mul_sel)
            M_HSHC: begin mul_a = 35'(hs_c);    mul_b = 33'(hc_c); end
            M_HCHC: begin mul_a = 35'(hc_c);    mul_b = 33'(hc_c); end
            M_HSHS: begin mul_a = 35'(hs_c);    mul_b = 33'(hs_c); end
            M_DX:   begin mul_a = 35'(dx_c);    mul_b = rad33; end
            M_DY:   begin mul_a = 35'(dy_c);    mul_b = rad33; end
            M_VX:   begin mul_a = 35'(sx_c);    mul_b = rad33; end
            M_VY:   begin mul_a = 35'(sy_c);    mul_b = rad33; end
            M_PXCY: begin mul_a = 35'(px_reg);  mul_b = 33'(cy_reg); end
            M_PYSY: begin mul_a = 35'(py_reg);  mul_b = 33'(sy_reg); end
            M_PXSY: begin mul_a = 35'(px_reg);  mul_b = 33'(sy_reg); end
            M_PYCY: begin mul_a = 35'(py_reg);  mul_b = 33'(cy_reg); end
            M_VXCY: begin mul_a = 35'(vx_reg);  mul_b = 33'(cy_reg); end
            M_VYSY: begin mul_a = 35'(vy_reg);  mul_b = 33'(sy_reg); end
            M_VXSY: begin mul_a = 35'(vx_reg);  mul_b = 33'(sy_reg); end
            M_VYCY: begin mul_a = 35'(vy_reg);  mul_b = 33'(cy_reg); end
            M_QXX:  begin mul_a = 35'(item_reg.quat_x_in); mul_b = 33'(item_reg.quat_x_in); end
            M_QYY:  begin mul_a = 35'(item_reg.quat_y_in); mul_b = 33'(item_reg.quat_y_in); end
            M_QZZ:  begin mul_a = 35'(item_reg.quat_z_in); mul_b = 33'(item_reg.quat_z_in); end
            M_QWW:  begin mul_a = 35'(item_reg.quat_w_in); mul_b = 33'(item_reg.quat_w_in); end
            M_QXY:  begin mul_a = 35'(item_reg.quat_x_in); mul_b = 33'(item_reg.quat_y_in); end
            M_QWZ:  begin mul_a = 35'(item_reg.quat_w_in); mul_b = 33'(item_reg.quat_z_in); end
            M_QXZ:  begin mul_a = 35'(item_reg.quat_x_in); mul_b = 33'(item_reg.quat_z_in); end
            M_QWY:  begin mul_a = 35'(item_reg.quat_w_in); mul_b = 33'(item_reg.quat_y_in); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // rounding of the registered product
    always_comb
    begin
        prod_w  = 69'(prod_reg);
        sub_sum = 69'(acc_reg) - prod_w;
        add_sum = 69'(acc_reg) + prod_w;
        r16     = (prod_w + RND16) >>> 16;
        r29     = (prod_w + RND29) >>> 29;
        sub30   = (sub_sum + RND30) >>> 30;
        add30   = (add_sum + RND30) >>> 30;
    end

    // cordic shifts and vectoring setup
    always_comb
    begin
        sh_x   = x_reg >>> cmd.step;
        sh_y   = y_reg >>> cmd.step;
        atan_c = $signed({2'b00, atan_tab(cmd.step)});
        ya2    = 38'(ya_reg) <<< 1;
        xa38   = 38'(xa_reg);
        g2     = 37'(g_reg) <<< 1;
        gabs   = (g2 < 0) ? -g2 : g2;
        vec_deg = (n_reg == 36'sd0) || (gabs >= 37'(n_reg)) ||
                  ((xa38 == 38'sd0) && (ya2 == 38'sd0));
        if (xa38 < 0)
        begin
            if (ya2 >= 0)
            begin
                vx_init = ya2;
                vy_init = -xa38;
                vz_init = HALF_PI_Q30;
            end
            else
            begin
                vx_init = -ya2;
                vy_init = xa38;
                vz_init = -HALF_PI_Q30;
            end
        end
        else
        begin
            vx_init = xa38;
            vy_init = ya2;
            vz_init = '0;
        end
        z_rnd = (35'(z_reg) + 35'sd65536) >>> 17;
        if (deg_reg)
            yaw_imu = '0;
        else if (z_rnd > 35'(PI_Q13))
            yaw_imu = PI_Q13[15:0];
        else if (z_rnd < -35'(PI_Q13))
            yaw_imu = -PI_Q13[15:0];
        else
            yaw_imu = z_rnd[15:0];
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
    end

    // multiplier, post-processing, cordic and result registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.post_sel)
            P_SY:  sy_reg <= clamp_q30(r29);
            P_ACC: acc_reg <= prod_reg;
            P_CY:  cy_reg <= clamp_q30(sub30);
            P_PX:  px_reg <= r16[33:0];
            P_PY:  py_reg <= r16[33:0];
            P_VX:  vx_reg <= r16[33:0];
            P_VY:  vy_reg <= r16[33:0];
            P_VWX: vwx_reg <= sat32(sub30);
            P_VWY: vwy_reg <= sat32(add30);
            P_QXX:
            begin
                n_reg  <= 36'(prod_reg);
                xa_reg <= 36'(prod_reg);
            end
            P_QYY:
            begin
                n_reg  <= n_reg + 36'(prod_reg);
                xa_reg <= xa_reg - 36'(prod_reg);
            end
            P_QZZ:
            begin
                n_reg  <= n_reg + 36'(prod_reg);
                xa_reg <= xa_reg - 36'(prod_reg);
            end
            P_QWW:
            begin
                n_reg  <= n_reg + 36'(prod_reg);
                xa_reg <= xa_reg + 36'(prod_reg);
            end
            P_QXY: ya_reg <= 36'(prod_reg);
            P_QWZ: ya_reg <= ya_reg + 36'(prod_reg);
            P_QXZ: g_reg <= 36'(prod_reg);
            P_QWY: g_reg <= g_reg - 36'(prod_reg);
            default: ;
        endcase

        case (cmd.cordic_op)
            CO_INIT_ROT:
            begin
                x_reg <= CORDIC_K_Q30;
                y_reg <= '0;
                z_reg <= 34'(yaw_c) <<< 16;
            end
            CO_INIT_VEC:
            begin
                x_reg   <= vx_init;
                y_reg   <= vy_init;
                z_reg   <= vz_init;
                deg_reg <= vec_deg;
            end
            CO_STEP_ROT:
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - sh_y;
                    y_reg <= y_reg + sh_x;
                    z_reg <= z_reg - atan_c;
                end
                else
                begin
                    x_reg <= x_reg + sh_y;
                    y_reg <= y_reg - sh_x;
                    z_reg <= z_reg + atan_c;
                end
            end
            CO_STEP_VEC:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + sh_y;
                    y_reg <= y_reg - sh_x;
                    z_reg <= z_reg + atan_c;
                end
                else
                begin
                    x_reg <= x_reg - sh_y;
                    y_reg <= y_reg + sh_x;
                    z_reg <= z_reg - atan_c;
                end
            end
            default: ;
        endcase

        if (cmd.emit)
        begin
            res_reg.pose_x         <= pose_x_reg;
            res_reg.pose_y         <= pose_y_reg;
            res_reg.heading        <= yaw_c;
            res_reg.heading_quat_z <= qz_rnd[15:0];
            res_reg.heading_quat_w <= qw_rnd[15:0];
            res_reg.vel_x_world    <= vwx_reg;
            res_reg.vel_y_world    <= vwy_reg;
            res_reg.yaw_rate_out   <= imu_rate_reg;
        end
    end

    // config, odometry state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg         <= RADIUS_RESET;
            inv_x_reg          <= 1'b0;
            inv_y_reg          <= 1'b0;
            use_imu_reg        <= 1'b1;
            angle_x_reg        <= '0;
            angle_y_reg        <= '0;
            prior_x_reg        <= '0;
            prior_y_reg        <= '0;
            speed_x_reg        <= '0;
            speed_y_reg        <= '0;
            pose_x_reg         <= '0;
            pose_y_reg         <= '0;
            imu_heading_reg    <= '0;
            imu_rate_reg       <= '0;
            heading_offset_reg <= '0;
            enc_fresh_reg      <= 1'b1;
            imu_fresh_reg      <= 1'b1;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_RADIUS:  radius_reg <= cfg_data;
                    REG_INV_X:   inv_x_reg <= cfg_data[0];
                    REG_INV_Y:   inv_y_reg <= cfg_data[0];
                    REG_USE_IMU: use_imu_reg <= cfg_data[0];
                    default: ;
                endcase
            end

            if (cmd.commit_enc)
            begin
                prior_x_reg   <= angle_x_reg;
                prior_y_reg   <= angle_y_reg;
                angle_x_reg   <= item_reg.pos_x_in;
                angle_y_reg   <= item_reg.pos_y_in;
                speed_x_reg   <= item_reg.speed_x_in;
                speed_y_reg   <= item_reg.speed_y_in;
                enc_fresh_reg <= 1'b1;
            end

            if (cmd.commit_pose)
            begin
                pose_x_reg <= item_reg.pos_x_in;
                pose_y_reg <= item_reg.pos_y_in;
                heading_offset_reg <=
                    wrap_q13(18'(item_reg.rate_or_yaw) - 18'(imu_heading_reg));
            end

            if (cmd.commit_imu)
            begin
                imu_heading_reg <= yaw_imu;
                imu_rate_reg    <= item_reg.rate_or_yaw;
                imu_fresh_reg   <= 1'b1;
            end

            // pose accumulation, wraps modulo 2^32
            case (cmd.post_sel)
                P_WX: pose_x_reg <= pose_x_reg + sub30[31:0];
                P_WY: pose_y_reg <= pose_y_reg + add30[31:0];
                default: ;
            endcase

            if (cmd.emit)
            begin
                enc_fresh_reg <= 1'b0;
                imu_fresh_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status and outputs
    always_comb
    begin
        stat.action   = item_reg.action;
        stat.use_imu  = use_imu_reg;
        stat.tick_ok  = enc_fresh_reg && (!use_imu_reg || imu_fresh_reg);
        stat.out_free = !out_valid_reg || out_ready;
        out_valid     = out_valid_reg;
        res           = res_reg;
    end

endmodule

@@ rtl/dwio_ctrl.sv @@
// dwio_ctrl: sequencer for the odometry core; decodes items and steps cordic and multiplies
// depends on dwio_pkg; commands dwio_dp
module dwio_ctrl
    import dwio_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam int NSTEP = (CORDIC_STEPS < 0) ? 0 :
                           ((CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS);
    localparam logic [4:0] LAST_STEP = 5'(NSTEP - 1);
    localparam logic [4:0] LAST_TICK = 5'(TICK_UOPS - 1);
    localparam logic [4:0] LAST_IMU = 5'(IMU_UOPS - 1);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DECODE  = 9'b000000010,
        S_QMUL    = 9'b000000100,
        S_VINIT   = 9'b000001000,
        S_VEC     = 9'b000010000,
        S_IMUDONE = 9'b000100000,
        S_ROT     = 9'b001000000,
        S_TMUL    = 9'b010000000,
        S_EMIT    = 9'b100000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    uop_t       uop;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.step   = cnt_reg;
        uop        = '{M_NONE, P_NONE};
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cnt_next = '0;
                case (stat.action)
                    ACT_ENC:
                    begin
                        cmd.commit_enc = 1'b1;
                        state_next     = S_IDLE;
                    end
                    ACT_POSE:
                    begin
                        cmd.commit_pose = 1'b1;
                        state_next      = S_IDLE;
                    end
                    ACT_IMU:
                        state_next = stat.use_imu ? S_QMUL : S_IDLE;
                    ACT_TICK:
                    begin
                        if (stat.tick_ok)
                        begin
                            cmd.cordic_op = CO_INIT_ROT;
                            state_next    = (NSTEP == 0) ? S_TMUL : S_ROT;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_QMUL:
            begin
                uop          = imu_uop(cnt_reg);
                cmd.mul_sel  = uop.mul;
                cmd.post_sel = uop.post;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == LAST_IMU)
                    state_next = S_VINIT;
            end
            S_VINIT:
            begin
                cmd.cordic_op = CO_INIT_VEC;
                cnt_next      = '0;
                state_next    = (NSTEP == 0) ? S_IMUDONE : S_VEC;
            end
            S_VEC:
            begin
                cmd.cordic_op = CO_STEP_VEC;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                    state_next = S_IMUDONE;
            end
            S_IMUDONE:
            begin
                cmd.commit_imu = 1'b1;
                state_next     = S_IDLE;
            end
            S_ROT:
            begin
                cmd.cordic_op = CO_STEP_ROT;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == LAST_STEP)
                begin
                    cnt_next   = '0;
                    state_next = S_TMUL;
                end
            end
            S_TMUL:
            begin
                uop          = tick_uop(cnt_reg);
                cmd.mul_sel  = uop.mul;
                cmd.post_sel = uop.post;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == LAST_TICK)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // a taken request is always decoded next
    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DECODE))
        else $error("accepted request not decoded");

    // a result is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over a pending result");

    // cordic step index stays inside the table
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ROT) || (state_reg == S_VEC)) |-> (cnt_reg <= LAST_STEP))
        else $error("cordic step out of range");

    // a stale tick goes straight back to idle
    a_stale_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECODE) && (stat.action == ACT_TICK) && !stat.tick_ok)
        |=> (state_reg == S_IDLE))
        else $error("stale tick started work");

endmodule
